FILE: design/kdq_pkg.sv
package kdq_pkg;

    localparam int NUM_KEYS = 3;
    localparam int CNT_W = 8;
    localparam int POS_W = 16;
    localparam logic [CNT_W-1:0] LIMIT_RESET = CNT_W'(10);

    // per-key pulses raised by one tick of the integrators
    typedef struct packed {
        logic [NUM_KEYS-1:0] pressed;
        logic [NUM_KEYS-1:0] released;
    } t_key_evt;

    // one sampled item held in the input register
    typedef struct packed {
        logic [NUM_KEYS-1:0] keys_low;
        logic                pin_a;
        logic                pin_b;
        logic [NUM_KEYS-1:0] ack_pressed;
        logic [NUM_KEYS-1:0] ack_released;
        logic                ack_changed;
    } t_sample;

endpackage

FILE: design/key_debounce_and_quadrature_decoder.sv
// an accepted item goes through the input register, then the state update
// that loads the result registers
// throughput: one item per cycle, limited only by the output stall
// the state registers double as the result registers, so they advance only when the
// result register is empty or its transfer happens in the same cycle
// reset (synchronous, active low): counters, key states, flags, pins and position cleared,
// debounce limit back to 10, both register stages empty
module key_debounce_and_quadrature_decoder
    import kdq_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [CNT_W-1:0]        i_cfg_wdata,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic [NUM_KEYS-1:0]     i_keys_low,
    input  logic                    i_enc_pin_a,
    input  logic                    i_enc_pin_b,
    input  logic [NUM_KEYS-1:0]     i_ack_pressed,
    input  logic [NUM_KEYS-1:0]     i_ack_released,
    input  logic                    i_ack_changed,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic [NUM_KEYS-1:0]     o_key_down,
    output logic [NUM_KEYS-1:0]     o_press_events,
    output logic [NUM_KEYS-1:0]     o_release_events,
    output logic signed [POS_W-1:0] o_enc_position,
    output logic                    o_enc_changed
);

    logic [CNT_W-1:0]    r_limit;
    logic                r_s1_valid;
    t_sample             r_s1;
    logic                r_out_valid;
    logic [NUM_KEYS-1:0] r_press;
    logic [NUM_KEYS-1:0] r_release;
    logic                r_changed;
    logic [NUM_KEYS-1:0] n_press;
    logic [NUM_KEYS-1:0] n_release;
    logic                n_changed;
    logic                out_free;
    logic                upd;
    logic                in_xfer;
    t_key_evt            key_evt;
    logic                enc_step;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign upd        = r_s1_valid && out_free;
    assign o_in_stall = r_s1_valid && !out_free;
    assign in_xfer    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RESET;
        end else if (i_cfg_we) begin
            r_limit <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_xfer || upd) begin
            r_s1_valid <= in_xfer;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s1.keys_low     <= i_keys_low;
            r_s1.pin_a        <= i_enc_pin_a;
            r_s1.pin_b        <= i_enc_pin_b;
            r_s1.ack_pressed  <= i_ack_pressed;
            r_s1.ack_released <= i_ack_released;
            r_s1.ack_changed  <= i_ack_changed;
        end
    end

    kdq_keys u_keys (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (upd),
        .i_keys_low (r_s1.keys_low),
        .i_limit    (r_limit),
        .o_held     (o_key_down),
        .o_evt      (key_evt)
    );

    kdq_enc u_enc (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (upd),
        .i_pin_a    (r_s1.pin_a),
        .i_pin_b    (r_s1.pin_b),
        .o_position (o_enc_position),
        .o_step     (enc_step)
    );

    // acknowledges clear first, so an event of the same tick survives
    always_comb begin
        n_press   = (r_press & ~r_s1.ack_pressed) | key_evt.pressed;
        n_release = (r_release & ~r_s1.ack_released) | key_evt.released;
        n_changed = (r_changed & ~r_s1.ack_changed) | enc_step;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_press     <= '0;
            r_release   <= '0;
            r_changed   <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_s1_valid;
            if (r_s1_valid) begin
                r_press   <= n_press;
                r_release <= n_release;
                r_changed <= n_changed;
            end
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_press_events   = r_press;
    assign o_release_events = r_release;
    assign o_enc_changed    = r_changed;

    a_press_on_rise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> ((o_key_down & ~$past(o_key_down) & ~o_press_events) == '0))
        else $error("key became held without a press event");

    a_release_on_fall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> ((~o_key_down & $past(o_key_down) & ~o_release_events) == '0))
        else $error("key released without a release event");

    a_pos_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && (o_enc_position != $past(o_enc_position))) |-> o_enc_changed)
        else $error("position moved without the changed flag");

    a_pos_unit_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> ((o_enc_position == $past(o_enc_position))
            || (o_enc_position == $past(o_enc_position) + POS_W'(1))
            || (o_enc_position == $past(o_enc_position) - POS_W'(1))))
        else $error("position stepped by more than one");

endmodule

FILE: design/kdq_keys.sv
module kdq_keys
    import kdq_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic [NUM_KEYS-1:0] i_keys_low,
    input  logic [CNT_W-1:0]    i_limit,
    output logic [NUM_KEYS-1:0] o_held,
    output t_key_evt            o_evt
);

    logic [CNT_W-1:0]    r_cnt [NUM_KEYS];
    logic [CNT_W-1:0]    n_cnt [NUM_KEYS];
    logic [NUM_KEYS-1:0] r_held;
    logic [NUM_KEYS-1:0] n_held;
    t_key_evt            evt;

    always_comb begin
        for (int i = 0; i < NUM_KEYS; i++) begin
            n_cnt[i]           = r_cnt[i];
            n_held[i]          = r_held[i];
            evt.pressed[i]     = 1'b0;
            evt.released[i]    = 1'b0;
            if (!i_keys_low[i]) begin
                // key reads pressed: integrate up to the limit
                if (r_cnt[i] < i_limit) begin
                    n_cnt[i] = r_cnt[i] + CNT_W'(1);
                    if ((n_cnt[i] == i_limit) && !r_held[i]) begin
                        n_held[i]      = 1'b1;
                        evt.pressed[i] = 1'b1;
                    end
                end
            end else if (r_cnt[i] != '0) begin
                n_cnt[i] = r_cnt[i] - CNT_W'(1);
                if ((n_cnt[i] == '0) && r_held[i]) begin
                    n_held[i]       = 1'b0;
                    evt.released[i] = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= '0;
            for (int i = 0; i < NUM_KEYS; i++) begin
                r_cnt[i] <= '0;
            end
        end else if (i_en) begin
            r_held <= n_held;
            for (int i = 0; i < NUM_KEYS; i++) begin
                r_cnt[i] <= n_cnt[i];
            end
        end
    end

    assign o_held = r_held;
    assign o_evt  = i_en ? evt : '0;

endmodule

FILE: design/kdq_enc.sv
module kdq_enc
    import kdq_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_pin_a,
    input  logic                    i_pin_b,
    output logic signed [POS_W-1:0] o_position,
    output logic                    o_step
);

    logic             r_last_a;
    logic             r_last_b;
    logic [POS_W-1:0] r_pos;
    logic             n_last_a;
    logic             n_last_b;
    logic [POS_W-1:0] n_pos;
    logic             step;
    logic             up;

    always_comb begin
        n_last_a = r_last_a;
        n_last_b = r_last_b;
        step     = 1'b0;
        up       = 1'b0;
        // contact a takes priority over contact b
        if (i_pin_a != r_last_a) begin
            n_last_a = i_pin_a;
            step     = 1'b1;
            up       = (i_pin_a == r_last_b);
        end else if (i_pin_b != r_last_b) begin
            n_last_b = i_pin_b;
            step     = 1'b1;
            up       = (r_last_a != i_pin_b);
        end
        if (!step) begin
            n_pos = r_pos;
        end else if (up) begin
            n_pos = r_pos + POS_W'(1);
        end else begin
            n_pos = r_pos - POS_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_a <= 1'b0;
            r_last_b <= 1'b0;
            r_pos    <= '0;
        end else if (i_en) begin
            r_last_a <= n_last_a;
            r_last_b <= n_last_b;
            r_pos    <= n_pos;
        end
    end

    assign o_position = $signed(r_pos);
    assign o_step     = i_en & step;

endmodule
